@@ hw/rtl/bodd_pkg.sv @@
package bodd_pkg;

    localparam int unsigned CountWidth = 25;
    localparam int unsigned SumWidth   = 32;

    localparam logic [CountWidth-1:0] PixelCountReset = 25'd301453;

    // binary start marker, in stream order
    localparam logic [7:0] Marker [4] = '{8'h0C, 8'h1A, 8'h04, 8'hD5};

    localparam logic [7:0]  EscShort = 8'h80;
    localparam logic [15:0] EscLong  = 16'h8000;

    // one-hot decode phases
    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_BYTE  = 4'b0010,
        PH_SHORT = 4'b0100,
        PH_LONG  = 4'b1000
    } phase_t;

    // one classified delta on its way to the accumulator
    typedef struct packed {
        logic [SumWidth-1:0] delta;
        logic                last;   // final pixel of the frame
        logic                first;  // first pixel after a marker: sum restarts
    } delta_item_t;

endpackage

@@ hw/rtl/bodd_front.sv @@
module bodd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bodd_pkg::CountWidth-1:0]      cfg_wr_data,
    input  logic                                 byte_valid,
    input  logic [7:0]                           byte_data,
    output logic                                 push,
    output bodd_pkg::delta_item_t                push_item
);

    bodd_pkg::phase_t                    phase_reg, phase_next;
    logic [1:0]                          prog_reg, prog_next;
    logic [1:0]                          seen_reg, seen_next;
    logic [23:0]                         part_reg, part_next;
    logic [bodd_pkg::CountWidth-1:0]     cnt_reg, cnt_next;
    logic [bodd_pkg::CountWidth-1:0]     pix_count_reg;
    logic                                first_reg, first_next;

    logic [bodd_pkg::CountWidth-1:0]     cnt_inc;
    logic                                is_last;
    logic [15:0]                         val16;
    logic [31:0]                         delta;
    logic                                emit;

    assign cnt_inc = cnt_reg + 1'b1;
    assign is_last = (cnt_inc >= pix_count_reg);
    assign val16   = {byte_data, part_reg[7:0]};

    always_comb begin
        phase_next = phase_reg;
        prog_next  = prog_reg;
        seen_next  = seen_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        emit       = 1'b0;
        delta      = {{24{byte_data[7]}}, byte_data};

        if (byte_valid) begin
            case (phase_reg)
                bodd_pkg::PH_BYTE: begin
                    if (byte_data == bodd_pkg::EscShort) begin
                        phase_next = bodd_pkg::PH_SHORT;
                        seen_next  = 2'd0;
                    end else begin
                        emit = 1'b1;
                    end
                end
                bodd_pkg::PH_SHORT: begin
                    if (seen_reg == 2'd0) begin
                        part_next[7:0] = byte_data;
                        seen_next      = 2'd1;
                    end else begin
                        seen_next = 2'd0;
                        if (val16 == bodd_pkg::EscLong) begin
                            phase_next = bodd_pkg::PH_LONG;
                        end else begin
                            phase_next = bodd_pkg::PH_BYTE;
                            delta      = {{16{val16[15]}}, val16};
                            emit       = 1'b1;
                        end
                    end
                end
                bodd_pkg::PH_LONG: begin
                    if (seen_reg == 2'd3) begin
                        seen_next  = 2'd0;
                        phase_next = bodd_pkg::PH_BYTE;
                        delta      = {byte_data, part_reg};
                        emit       = 1'b1;
                    end else begin
                        part_next[seen_reg*8 +: 8] = byte_data;
                        seen_next                  = seen_reg + 2'd1;
                    end
                end
                default: begin
                    // marker hunt; a stray 0x0C restarts the match at one
                    if (byte_data == bodd_pkg::Marker[prog_reg]) begin
                        if (prog_reg == 2'd3) begin
                            prog_next  = 2'd0;
                            phase_next = bodd_pkg::PH_BYTE;
                            cnt_next   = '0;
                            seen_next  = 2'd0;
                            first_next = 1'b1;
                        end else begin
                            prog_next = prog_reg + 2'd1;
                        end
                    end else begin
                        prog_next = (byte_data == bodd_pkg::Marker[0]) ? 2'd1 : 2'd0;
                    end
                end
            endcase

            if (emit) begin
                cnt_next   = cnt_inc;
                first_next = 1'b0;
                if (is_last) begin
                    phase_next = bodd_pkg::PH_HUNT;
                    prog_next  = 2'd0;
                end
            end
        end
    end

    assign push            = emit;
    assign push_item.delta = delta;
    assign push_item.last  = is_last;
    assign push_item.first = first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= bodd_pkg::PH_HUNT;
            prog_reg      <= 2'd0;
            seen_reg      <= 2'd0;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            pix_count_reg <= bodd_pkg::PixelCountReset;
        end else begin
            phase_reg <= phase_next;
            prog_reg  <= prog_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            if (cfg_wr_en) begin
                pix_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
    end

endmodule

@@ hw/rtl/bodd_queue.sv @@
module bodd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  bodd_pkg::delta_item_t push_item,
    output logic                  full,
    output logic                  pop_valid,
    input  logic                  pop,
    output bodd_pkg::delta_item_t pop_item
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

    bodd_pkg::delta_item_t slot_reg [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntWidth-1:0]   fill_reg;
    logic                  do_pop;

    assign full      = (fill_reg == CntFull);
    assign pop_valid = (fill_reg != '0);
    assign do_pop    = pop && pop_valid;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/bodd_back.sv @@
module bodd_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               item_valid,
    input  bodd_pkg::delta_item_t              item,
    output logic                               item_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bodd_pkg::SumWidth-1:0]      m_tdata,
    output logic                               m_tlast
);

    logic [bodd_pkg::SumWidth-1:0] sum_reg, sum_next;
    logic [bodd_pkg::SumWidth-1:0] out_data_reg;
    logic                          out_last_reg;
    logic                          out_valid_reg;

    assign item_pop = item_valid && (!out_valid_reg || m_tready);
    assign sum_next = (item.first ? '0 : sum_reg) + item.delta;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end else begin
            if (item_pop) begin
                out_valid_reg <= 1'b1;
                sum_reg       <= sum_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            out_data_reg <= sum_next;
            out_last_reg <= item.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/byte_offset_delta_decoder.sv @@
// Byte-offset delta decoder. Takes one raw byte per item on the s_ stream, hunts
// for the start marker 0C 1A 04 D5, then decodes 8-, 16- and 32-bit deltas
// (escapes 0x80 and 0x8000) into a wrapping 32-bit running sum, giving one pixel
// per delta on the m_ stream; the pixel_count-th pixel carries tlast and the
// decoder goes back to hunting. Throughput is one byte per clock while the queue
// has room: a byte is classified in the cycle it is accepted, its delta is written
// into the queue, and the sum is formed from the queue head and registered in the
// output register. The front stalls only when the delta queue is full; the
// queue depth sets how far the output may stall before s_tready drops.
// cfg_wr_data (pixel_count) must be written with no frame in flight; 0 acts as 1.
module byte_offset_delta_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,

    // pixel_count register
    input  logic        cfg_wr_en,
    input  logic [24:0] cfg_wr_data,

    // compressed byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte

    // decoded pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] pixel_value (two's complement)
    output logic        m_tlast    // last_pixel
);

    logic                  q_full;
    logic                  push;
    bodd_pkg::delta_item_t push_item;
    logic                  q_valid;
    logic                  q_pop;
    bodd_pkg::delta_item_t q_item;

    // a byte may emit at most one delta, so a free slot is all the front needs
    assign s_tready = !q_full;

    // front: marker hunt, escape handling and frame pixel count
    bodd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (s_tvalid && s_tready),
        .byte_data   (s_tdata),
        .push        (push),
        .push_item   (push_item)
    );

    // short queue of classified deltas between the two halves
    bodd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_item  (q_item)
    );

    // back: running sum and registered output item
    bodd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
